[design/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define FCF_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fcf assertion failed");

// short form on the block clock and reset
`define FCF_ASSERT_CK(name, prop) `FCF_ASSERT(name, clk_i, rst_ni, prop)

`endif

[design/fcf_pkg.sv]
package fcf_pkg;

  localparam int TAPS_DEFAULT = 64;
  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 18;
  localparam int TAP_IDX_W    = 6;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int ROUND_SHIFT  = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int SAMPLE_MAX   = 8388607;
  localparam int SAMPLE_MIN   = -8388608;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [TAP_IDX_W-1:0] tap_idx;
    logic signed [COEF_W-1:0]    tap_val;
  } cmd_t;

endpackage

[design/fcf_front.sv]
module fcf_front #(
  parameter int TAPS = fcf_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clearing_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [fcf_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [fcf_pkg::COEF_W-1:0]   tap_value_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output fcf_pkg::cmd_t                       push_cmd_o
);
  import fcf_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic keep;

  // loads aimed past the last tap are dropped here
  assign keep       = (operation_i == OP_SAMPLE) || (32'(tap_index_i) < 32'(TAPS));
  assign in_ready_o = !clearing_i && (!vld_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (vld_q && push_ready_i) begin
      vld_d = 1'b0;
    end
    if (accept && keep) begin
      vld_d         = 1'b1;
      cmd_d.op      = op_e'(operation_i);
      cmd_d.sample  = sample_in_i;
      cmd_d.tap_idx = tap_index_i;
      cmd_d.tap_val = tap_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      vld_q <= vld_d;
      cmd_q <= cmd_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_cmd_o   = cmd_q;

endmodule

[design/fcf_queue.sv]
module fcf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  fcf_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output fcf_pkg::cmd_t pop_cmd_o
);
  import fcf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[design/fcf_back.sv]
module fcf_back #(
  parameter int TAPS = fcf_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  fcf_pkg::cmd_t                       pop_cmd_i,
  output logic                                clearing_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fcf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                saturated_o
);
  import fcf_pkg::*;

  localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int ACC_W = PROD_W + IDX_W + 1;
  localparam int RND_W = ACC_W - ROUND_SHIFT;
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(TAPS - 1);
  localparam logic [CNT_W-1:0]        WARM_END = CNT_W'(TAPS);
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [RND_W-1:0] RND_MAX  = RND_W'(SAMPLE_MAX);
  localparam logic signed [RND_W-1:0] RND_MIN  = RND_W'(SAMPLE_MIN);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_OUT
  } state_e;

  state_e state_q;

  logic signed [COEF_W-1:0]   coef_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly_mem  [TAPS];
  logic signed [COEF_W-1:0]   coef_rd_q;
  logic signed [SAMPLE_W-1:0] dly_rd_q;

  logic [IDX_W-1:0] clr_idx_q, newest_q, rd_idx_q, pos_q, newest_nxt;
  logic [CNT_W-1:0] warm_q;
  logic             rd_vld_q, rd_last_q, mul_vld_q, mul_last_q;
  logic signed [PROD_W-1:0] prod_q, mul_full;
  logic signed [ACC_W-1:0]  acc_q, rnd_sum;
  logic signed [RND_W-1:0]  rnd_q;

  logic                       out_valid_q, out_sat_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;

  logic                       pop, coef_we, dly_we, rd_en, out_free, sat_hi, sat_lo;
  logic [IDX_W-1:0]           coef_wa;
  logic signed [COEF_W-1:0]   coef_wd;
  logic signed [SAMPLE_W-1:0] res;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign clearing_o  = (state_q == ST_CLEAR);

  always_comb begin
    coef_we    = clearing_o || (pop && pop_cmd_i.op == OP_LOAD);
    coef_wa    = clearing_o ? clr_idx_q : IDX_W'(pop_cmd_i.tap_idx);
    coef_wd    = clearing_o ? '0 : pop_cmd_i.tap_val;
    dly_we     = pop && (pop_cmd_i.op == OP_SAMPLE);
    newest_nxt = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
    rd_en      = (state_q == ST_RUN);
    mul_full   = PROD_W'(dly_rd_q) * PROD_W'(coef_rd_q);
    rnd_sum    = acc_q + RND_BIAS;
    out_free   = !out_valid_q || out_ready_i;
    sat_hi     = (rnd_q > RND_MAX);
    sat_lo     = (rnd_q < RND_MIN);
    if (sat_hi) begin
      res = SAMPLE_W'(SAMPLE_MAX);
    end else if (sat_lo) begin
      res = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      res = rnd_q[SAMPLE_W-1:0];
    end
  end

  // tap table and delay line, one port each
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= coef_wd;
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[rd_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[newest_nxt] <= pop_cmd_i.sample;
    end
    if (rd_en) begin
      dly_rd_q <= dly_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      newest_q     <= '0;
      warm_q       <= '0;
      rd_idx_q     <= '0;
      pos_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      mul_vld_q    <= 1'b0;
      mul_last_q   <= 1'b0;
      prod_q       <= '0;
      acc_q        <= '0;
      rnd_q        <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      rd_vld_q   <= rd_en;
      rd_last_q  <= rd_en && (rd_idx_q == LAST_IDX);
      mul_vld_q  <= rd_vld_q;
      mul_last_q <= rd_last_q;
      prod_q     <= mul_full;
      if (mul_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == LAST_IDX) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop && pop_cmd_i.op == OP_SAMPLE) begin
            newest_q <= newest_nxt;
            if (warm_q < WARM_END) begin
              warm_q  <= warm_q + 1'b1;
              rnd_q   <= '0;
              state_q <= ST_OUT;
            end else begin
              acc_q    <= '0;
              rd_idx_q <= '0;
              pos_q    <= newest_nxt;
              state_q  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          pos_q    <= (pos_q == '0) ? LAST_IDX : pos_q - 1'b1;
          if (rd_idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mul_vld_q && mul_last_q) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_q   <= rnd_sum[ACC_W-1:ROUND_SHIFT];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (state_q == ST_OUT && out_free) begin
        out_valid_q  <= 1'b1;
        out_sample_q <= res;
        out_sat_q    <= sat_hi || sat_lo;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign saturated_o  = out_sat_q;

endmodule

[design/fir_convolution_filter.sv]
// channel | direction | handshake               | payload
// in      | to block  | in_valid_i / in_ready_o   | operation_i, sample_in_i, tap_index_i, tap_value_i
// out     | from block| out_valid_o / out_ready_i | sample_out_o, saturated_o
//
// a filtered sample runs in the engine on one shared multiply-accumulate, which
// walks the tap table and delay line one tap per cycle through single-port memories
// a coefficient load is written straight from idle, and a warm-up sample skips the mac
// after reset a clearing pass zeroes the tap table; in_ready_o stays low
// a two-beat queue parts intake from the engine, and the output register lets the
// engine finish the next beat while a result waits for out_ready_i
module fir_convolution_filter #(
  parameter int TAPS = fcf_pkg::TAPS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic signed [fcf_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [fcf_pkg::TAP_IDX_W-1:0]       tap_index_i,
  input  logic signed [fcf_pkg::COEF_W-1:0]   tap_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fcf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                saturated_o
);
  import fcf_pkg::*;

  // intake to queue
  logic push_valid, push_ready;
  cmd_t push_cmd;
  // queue to engine
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;
  // engine busy zeroing the tap table
  logic clearing;

  // intake stage: registers the beat and drops loads past the last tap
  fcf_front #(
    .TAPS (TAPS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_i   (clearing),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .sample_in_i  (sample_in_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // short decoupling queue
  fcf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // engine: tap writes, delay line, mac, rounding, saturation and output register
  fcf_back #(
    .TAPS (TAPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_cmd_i    (pop_cmd),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o)
  );

endmodule

[design/fcf_checker.sv]
`include "assert_macros.svh"

module fcf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [fcf_pkg::SAMPLE_W-1:0] sample_out_o,
  input logic                                saturated_o
);

  // a stalled result holds its beat
  `FCF_ASSERT_CK(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sample_out_o) && $stable(saturated_o)))

  // a clipped result sits on one of the range limits
  `FCF_ASSERT_CK(a_sat_limit, (out_valid_o && saturated_o) |-> (sample_out_o == 24'sh7fffff || sample_out_o == 24'sh800000))

  // the tap table is still being cleared right after reset
  `FCF_ASSERT_CK(a_clear_after_reset, $rose(rst_ni) |-> !in_ready_o)

endmodule

bind fir_convolution_filter fcf_checker u_fcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .saturated_o  (saturated_o)
);
